FILE: design/hpool_pkg.sv
// Shared types and constants for the generational handle pool.
// No dependencies; every other design file refers to it by scoped names.
package hpool_pkg;

   localparam int SLOTS = 8;

   localparam int GEN_W    = 16;
   localparam int HANDLE_W = 32;
   localparam int HIDX_W   = HANDLE_W - GEN_W;     // index half of a handle
   localparam int IDX_W    = $clog2(SLOTS + 1);    // slot number 0..SLOTS
   localparam int CNT_W    = $clog2(SLOTS + 1);    // free count 0..SLOTS
   localparam int STK_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_OUT_W = 4;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [HANDLE_W-1:0] handle;
   } req_item_type;

   typedef struct packed {
      logic [HANDLE_W-1:0]   new_handle;
      logic [SLOT_OUT_W-1:0] slot_index;
      logic [STATUS_W-1:0]   status;
   } rsp_item_type;

endpackage

FILE: design/hpool_in_stage.sv
// Input register of the handle pool: holds one request word until the core takes it.
// Depends on hpool_pkg.
module hpool_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hpool_pkg::req_item_type req_item,
   input  logic                  take,
   output logic                  item_valid,
   output hpool_pkg::req_item_type item
);

   logic                    valid_ff, valid_in;
   hpool_pkg::req_item_type item_ff, item_in;
   logic                    load;

   // room when empty or when the held word leaves this cycle
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: design/hpool_core.sv
// Slot table, generation counters and LIFO free stack; one request per cycle on commit.
// Depends on hpool_pkg.
module hpool_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    commit,
   input  hpool_pkg::req_item_type item,
   output hpool_pkg::rsp_item_type result
);

   localparam int SLOTS = hpool_pkg::SLOTS;
   localparam int IDX_W = hpool_pkg::IDX_W;
   localparam int CNT_W = hpool_pkg::CNT_W;
   localparam int STK_W = hpool_pkg::STK_W;
   localparam int GEN_W = hpool_pkg::GEN_W;
   localparam int HIDX_W = hpool_pkg::HIDX_W;

   logic [IDX_W-1:0] stack_ff [SLOTS];
   logic [IDX_W-1:0] stack_in [SLOTS];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [GEN_W-1:0] gen_ff [SLOTS+1];
   logic [GEN_W-1:0] gen_in [SLOTS+1];
   logic             live_ff [SLOTS+1];
   logic             live_in [SLOTS+1];

   logic [HIDX_W-1:0] h_idx;
   logic [GEN_W-1:0]  h_gen;
   logic              h_range_ok;
   logic [CNT_W-1:0]  count_dec;
   logic [IDX_W-1:0]  top_idx;
   logic              is_alloc;
   logic [IDX_W-1:0]  addr;
   logic [GEN_W-1:0]  gen_rd;
   logic              live_rd;
   logic [GEN_W-1:0]  gen_next;
   logic              h_valid;

   assign h_idx = item.handle[HIDX_W-1:0];
   assign h_gen = item.handle[hpool_pkg::HANDLE_W-1:HIDX_W];
   assign h_range_ok = (item.handle != '0) && (h_idx != '0) &&
                       (h_idx <= HIDX_W'(SLOTS));

   assign count_dec = count_ff - CNT_W'(1);
   assign top_idx   = stack_ff[count_dec[STK_W-1:0]];
   assign is_alloc  = (item.command == hpool_pkg::CMD_ALLOC);

   // one slot is touched per word: stack top on allocate, the handle's slot otherwise
   always_comb begin
      if (is_alloc) begin
         addr = top_idx;
      end else if (h_range_ok) begin
         addr = h_idx[IDX_W-1:0];
      end else begin
         addr = '0;
      end
   end

   assign gen_rd  = gen_ff[addr];
   assign live_rd = live_ff[addr];

   // generation wraps past zero to one
   always_comb begin
      gen_next = gen_rd + GEN_W'(1);
      if (gen_next == '0) begin
         gen_next = GEN_W'(1);
      end
   end

   assign h_valid = h_range_ok && live_rd && (gen_rd == h_gen);

   always_comb begin
      stack_in = stack_ff;
      count_in = count_ff;
      gen_in   = gen_ff;
      live_in  = live_ff;
      result.new_handle = '0;
      result.slot_index = '0;
      result.status     = hpool_pkg::STATUS_INVALID;
      case (item.command)
         hpool_pkg::CMD_ALLOC: begin
            if (count_ff == '0) begin
               result.status = hpool_pkg::STATUS_EMPTY;
            end else begin
               count_in     = count_dec;
               gen_in[addr] = gen_next;
               live_in[addr] = 1'b1;
               result.new_handle = {gen_next, HIDX_W'(top_idx)};
               result.slot_index = hpool_pkg::SLOT_OUT_W'(top_idx);
               result.status     = hpool_pkg::STATUS_OK;
            end
         end
         hpool_pkg::CMD_RELEASE: begin
            if (h_valid && (count_ff < CNT_W'(SLOTS))) begin
               live_in[addr] = 1'b0;
               stack_in[count_ff[STK_W-1:0]] = addr;
               count_in = count_ff + CNT_W'(1);
               result.slot_index = hpool_pkg::SLOT_OUT_W'(addr);
               result.status     = hpool_pkg::STATUS_OK;
            end
         end
         hpool_pkg::CMD_LOOKUP: begin
            if (h_valid) begin
               result.slot_index = hpool_pkg::SLOT_OUT_W'(addr);
               result.status     = hpool_pkg::STATUS_OK;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(SLOTS);
         for (int i = 0; i < SLOTS; i++) begin
            stack_ff[i] <= IDX_W'(SLOTS - i);
         end
         for (int i = 0; i <= SLOTS; i++) begin
            gen_ff[i]  <= '0;
            live_ff[i] <= 1'b0;
         end
      end else if (commit) begin
         count_ff <= count_in;
         stack_ff <= stack_in;
         gen_ff   <= gen_in;
         live_ff  <= live_in;
      end
   end

endmodule

FILE: design/hpool_out_stage.sv
// Result register of the handle pool: holds a response word while the consumer stalls.
// Depends on hpool_pkg.
module hpool_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   output logic                    take,
   input  hpool_pkg::rsp_item_type result,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hpool_pkg::rsp_item_type rsp_item
);

   logic                    valid_ff, valid_in;
   hpool_pkg::rsp_item_type item_ff, item_in;

   assign take = item_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

FILE: design/generational_handle_pool_unit.sv
// Generational handle pool, top level. An accepted word is held in the input register,
// then its response in the result register on rsp_; throughput one word per cycle while
// rsp_ is not stalled, set by the single read-modify-write of the slot table in between.
// Synchronous active-high reset empties both registers, fills the free stack with
// slot 1 on top and clears every generation and live flag; no clearing pass.
// Depends on hpool_pkg, hpool_in_stage, hpool_core and hpool_out_stage.
module generational_handle_pool_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_new_handle,
   output logic [3:0]  rsp_slot_index,
   output logic [1:0]  rsp_status
);

   hpool_pkg::req_item_type req_item;
   hpool_pkg::req_item_type item;
   hpool_pkg::rsp_item_type result;
   hpool_pkg::rsp_item_type rsp_item;
   logic                    item_valid;
   logic                    take;

   assign req_item.command = req_command;
   assign req_item.handle  = req_handle;

   hpool_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   hpool_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (take),
      .item   (item),
      .result (result)
   );

   hpool_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .take       (take),
      .result     (result),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

   assign rsp_new_handle = rsp_item.new_handle;
   assign rsp_slot_index = rsp_item.slot_index;
   assign rsp_status     = rsp_item.status;

endmodule

FILE: design/hpool_checker.sv
// Port-level checks for the generational handle pool, bound to the top level.
// Depends on hpool_pkg and generational_handle_pool_unit.
module hpool_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_new_handle,
   input logic [3:0]  rsp_slot_index,
   input logic [1:0]  rsp_status
);

   // no response word survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_handle) &&
      $stable(rsp_slot_index) && $stable(rsp_status))
      else $error("stalled response word changed");

   // failures carry no handle and no slot
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != hpool_pkg::STATUS_OK) |->
      (rsp_new_handle == '0) && (rsp_slot_index == '0))
      else $error("failed response carries a handle or slot");

   // a fresh handle names its own slot and never has generation zero
   a_alloc_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_new_handle != '0) |->
      (rsp_status == hpool_pkg::STATUS_OK) &&
      (rsp_new_handle[15:0] == 16'(rsp_slot_index)) &&
      (rsp_new_handle[31:16] != '0) && (rsp_slot_index != '0))
      else $error("malformed allocated handle");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_slot_index <= 4'(hpool_pkg::SLOTS)) &&
      (rsp_status != 2'd3))
      else $error("slot or status out of range");

endmodule

bind generational_handle_pool_unit hpool_checker u_hpool_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_new_handle (rsp_new_handle),
   .rsp_slot_index (rsp_slot_index),
   .rsp_status     (rsp_status)
);
